### sv/pcu_pkg.sv
// Package for the polygon point containment unit.
// Holds the coordinate and vertex types, opcodes, controller states and box helpers.
// No dependencies.
`default_nettype none

package pcu_pkg;

   localparam int COORD_W          = 20;
   localparam int MAX_VERTICES_DEF = 64;
   localparam int COUNT_OUT_W      = 7;

   // The box half side is 1.5 in a format with 4 fraction bits.
   localparam logic signed [COORD_W:0] HALF_SIDE = (COORD_W + 1)'(24);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COORD_W:0]   coord_ext_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vertex_type;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_QUERY = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // The drain state lets the edge tester finish its last edge; it ends when the drain counter reaches this value.
   localparam logic [1:0] DRAIN_LAST = 2'd2;

   typedef struct packed {
      logic start;
      logic test;
   } edge_ctrl_type;

   function automatic coord_type sat_coord(coord_ext_type v);
      coord_type r;
      if (v[COORD_W] != v[COORD_W-1]) begin
         r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/pcu_cell.sv
// One vertex cell of the circular vertex chain.
// Loads an appended vertex or takes its neighbor's vertex on a shift.
// Depends on pcu_pkg.
`default_nettype none

module pcu_cell import pcu_pkg::*; (
   input  wire logic       clock,
   input  wire logic       load_en,
   input  wire logic       shift_en,
   input  wire vertex_type load_vert,
   input  wire vertex_type nbr_vert,
   output vertex_type      cell_vert
);

   vertex_type vert_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         vert_ff <= load_vert;
      end else if (shift_en) begin
         vert_ff <= nbr_vert;
      end
   end

   assign cell_vert = vert_ff;

endmodule

`default_nettype wire

### sv/pcu_edge.sv
// Three-stage edge crossing tester with left and right crossing parities.
// Uses cross-multiplication of the edge against a horizontal line through the point.
// Depends on pcu_pkg.
`default_nettype none

module pcu_edge import pcu_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire edge_ctrl_type ctrl,
   input  wire vertex_type    vert_a,
   input  wire vertex_type    vert_b,
   input  wire vertex_type    pnt,
   output logic               in_poly
);

   localparam int DW = COORD_W + 1;
   localparam int PW = 2 * DW;

   coord_ext_type          ax, ay, bx, by, px, py;
   coord_ext_type          dy;
   logic                   in_range;
   logic                   s1_valid_in;

   logic                   s1_valid_ff;
   logic signed [DW-1:0]   s1_dxa_ff, s1_dy_ff, s1_dyp_ff, s1_dxb_ff;
   logic                   s2_valid_ff;
   logic                   s2_dyneg_ff;
   logic signed [PW-1:0]   s2_p1_ff, s2_p2_ff;
   logic signed [PW:0]     num;
   logic                   right;
   logic                   lpar_ff, rpar_ff;

   always_comb begin
      ax = {vert_a.x[COORD_W-1], vert_a.x};
      ay = {vert_a.y[COORD_W-1], vert_a.y};
      bx = {vert_b.x[COORD_W-1], vert_b.x};
      by = {vert_b.y[COORD_W-1], vert_b.y};
      px = {pnt.x[COORD_W-1], pnt.x};
      py = {pnt.y[COORD_W-1], pnt.y};
      dy = by - ay;
      if (dy[DW-1]) begin
         in_range = (py <= ay) && (py >= by);
      end else begin
         in_range = (py >= ay) && (py <= by);
      end
      s1_valid_in = ctrl.test && (dy != '0) && in_range;
   end

   always_ff @(posedge clock) begin
      s1_dxa_ff <= ax - px;
      s1_dy_ff  <= dy;
      s1_dyp_ff <= py - ay;
      s1_dxb_ff <= bx - ax;
      s2_p1_ff    <= s1_dxa_ff * s1_dy_ff;
      s2_p2_ff    <= s1_dyp_ff * s1_dxb_ff;
      s2_dyneg_ff <= s1_dy_ff[DW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_comb begin
      num = {s2_p1_ff[PW-1], s2_p1_ff} + {s2_p2_ff[PW-1], s2_p2_ff};
      if (s2_dyneg_ff) begin
         right = num[PW];
      end else begin
         right = !num[PW] && (num != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.start) begin
         lpar_ff <= 1'b0;
         rpar_ff <= 1'b0;
      end else if (s2_valid_ff) begin
         if (right) begin
            rpar_ff <= !rpar_ff;
         end else begin
            lpar_ff <= !lpar_ff;
         end
      end
   end

   assign in_poly = lpar_ff || rpar_ff;

endmodule

`default_nettype wire

### sv/polygon_point_containment_unit.sv
// Add, clear and ignored opcodes: the result is registered at acceptance,
// and a new transaction can be accepted in every cycle while results are taken.
// Query: the vertex chain rotates once through all MAX_VERTICES cells and feeds one
// edge per cycle to a three-stage tester; the controller then passes through the drain and
// done states, and no new request is taken until it is back in idle.
// Reset is synchronous and clears the controller, vertex count and box; cells are not cleared.
`default_nettype none

module polygon_point_containment_unit import pcu_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_opcode,
   input  wire logic signed [COORD_W-1:0] req_x_coord,
   input  wire logic signed [COORD_W-1:0] req_y_coord,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_inside_res,
   output logic                           rsp_overflow,
   output logic [COUNT_OUT_W-1:0]         rsp_vertex_count,
   output logic signed [COORD_W-1:0]      rsp_box_left,
   output logic signed [COORD_W-1:0]      rsp_box_top,
   output logic signed [COORD_W-1:0]      rsp_box_right,
   output logic signed [COORD_W-1:0]      rsp_box_bottom
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int EXT_W = CNT_W + COUNT_OUT_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
   localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [1:0]       drain_ff, drain_in;
   logic [CNT_W-1:0] count_ff, count_in;
   coord_type        left_ff, top_ff, right_ff, bottom_ff;
   coord_type        left_in, top_in, right_in, bottom_in;
   vertex_type       pnt_ff, first_ff, prev_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_inside_ff, rsp_overflow_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   coord_type        rsp_left_ff, rsp_top_ff, rsp_right_ff, rsp_bottom_ff;
   logic [EXT_W-1:0] count_ext;

   opcode_type       req_op;
   logic             is_add, is_clear, is_query;
   logic             req_accept, out_free, full;
   logic             add_load, imm_load, done_load;
   logic             shift_en, closing;
   edge_ctrl_type    edge_ctrl;
   vertex_type       req_vert, vert_b;
   vertex_type       cell_q [MAX_VERTICES];
   logic             edge_inside;
   coord_type        sq_l, sq_t, sq_r, sq_b;
   coord_ext_type    x_ext, y_ext;
   logic             outside;

   assign req_op   = opcode_type'(req_opcode);
   assign req_vert = '{x: req_x_coord, y: req_y_coord};

   always_comb begin
      is_add   = 1'b0;
      is_clear = 1'b0;
      is_query = 1'b0;
      unique case (req_op)
         OP_ADD:   is_add = 1'b1;
         OP_CLEAR: is_clear = 1'b1;
         OP_QUERY: is_query = 1'b1;
         default: ;
      endcase
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign full       = (count_ff == CNT_MAX);
   assign add_load   = req_accept && is_add && !full;
   assign imm_load   = req_accept && !is_query;

   // Vertex chain: each cell hands its vertex to the one below on a shift.
   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      pcu_cell u_cell (
         .clock     (clock),
         .load_en   (add_load && (count_ff[IDX_W-1:0] == IDX_W'(i))),
         .shift_en  (shift_en),
         .load_vert (req_vert),
         .nbr_vert  (cell_q[(i + 1) % MAX_VERTICES]),
         .cell_vert (cell_q[i])
      );
   end

   always_comb begin
      x_ext   = {req_x_coord[COORD_W-1], req_x_coord};
      y_ext   = {req_y_coord[COORD_W-1], req_y_coord};
      sq_l    = sat_coord(x_ext - HALF_SIDE);
      sq_r    = sat_coord(x_ext + HALF_SIDE);
      sq_t    = sat_coord(y_ext - HALF_SIDE);
      sq_b    = sat_coord(y_ext + HALF_SIDE);
      outside = !((req_x_coord >= left_ff) && (req_x_coord <= right_ff) &&
                  (req_y_coord >= top_ff) && (req_y_coord <= bottom_ff));
      left_in   = left_ff;
      top_in    = top_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      count_in  = count_ff;
      if (add_load) begin
         count_in = count_ff + CNT_W'(1);
         if (count_ff == '0) begin
            left_in   = sq_l;
            top_in    = sq_t;
            right_in  = sq_r;
            bottom_in = sq_b;
         end else if (outside) begin
            if (sq_l < left_ff)   left_in = sq_l;
            if (sq_t < top_ff)    top_in = sq_t;
            if (sq_r > right_ff)  right_in = sq_r;
            if (sq_b > bottom_ff) bottom_in = sq_b;
         end
      end else if (req_accept && is_clear) begin
         count_in = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_accept && is_query) state_in = ST_SCAN;
         ST_SCAN:  if (step_ff == CNT_MAX) state_in = ST_DRAIN;
         ST_DRAIN: if (drain_ff == DRAIN_LAST) state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      shift_en        = 1'b0;
      closing         = 1'b0;
      done_load       = 1'b0;
      edge_ctrl.start = 1'b0;
      edge_ctrl.test  = 1'b0;
      step_in         = '0;
      drain_in        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            edge_ctrl.start = req_accept && is_query;
         end
         ST_SCAN: begin
            step_in        = step_ff + CNT_W'(1);
            shift_en       = (step_ff != CNT_MAX);
            closing        = (step_ff == count_ff);
            edge_ctrl.test = (count_ff >= CNT_TWO) && (step_ff != '0) &&
                             (step_ff <= count_ff);
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
         end
         ST_DONE: begin
            done_load = out_free;
         end
         default: ;
      endcase
   end

   assign vert_b = closing ? first_ff : cell_q[0];

   pcu_edge u_edge (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (edge_ctrl),
      .vert_a  (prev_ff),
      .vert_b  (vert_b),
      .pnt     (pnt_ff),
      .in_poly (edge_inside)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (imm_load || done_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         drain_ff     <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         top_ff       <= '0;
         right_ff     <= '0;
         bottom_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         drain_ff     <= drain_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         top_ff       <= top_in;
         right_ff     <= right_in;
         bottom_ff    <= bottom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (edge_ctrl.start) begin
         pnt_ff <= req_vert;
      end
      if (state_ff == ST_SCAN) begin
         prev_ff <= cell_q[0];
         if (step_ff == '0) begin
            first_ff <= cell_q[0];
         end
      end
      if (imm_load || done_load) begin
         rsp_inside_ff   <= done_load && edge_inside;
         rsp_overflow_ff <= imm_load && is_add && full;
         rsp_count_ff    <= count_in;
         rsp_left_ff     <= left_in;
         rsp_top_ff      <= top_in;
         rsp_right_ff    <= right_in;
         rsp_bottom_ff   <= bottom_in;
      end
   end

   assign count_ext        = EXT_W'(rsp_count_ff);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = rsp_inside_ff;
   assign rsp_overflow     = rsp_overflow_ff;
   assign rsp_vertex_count = count_ext[COUNT_OUT_W-1:0];
   assign rsp_box_left     = rsp_left_ff;
   assign rsp_box_top      = rsp_top_ff;
   assign rsp_box_right    = rsp_right_ff;
   assign rsp_box_bottom   = rsp_bottom_ff;

endmodule

`default_nettype wire

### sv/pcu_checker.sv
// Port-level checker for the polygon point containment unit, with its bind statement.
// Watches the result channel for stability and box and flag consistency.
// Depends on pcu_pkg.
`default_nettype none

module pcu_checker import pcu_pkg::*; (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic                      rsp_inside_res,
   input wire logic                      rsp_overflow,
   input wire logic [COUNT_OUT_W-1:0]    rsp_vertex_count,
   input wire logic signed [COORD_W-1:0] rsp_box_left,
   input wire logic signed [COORD_W-1:0] rsp_box_top,
   input wire logic signed [COORD_W-1:0] rsp_box_right,
   input wire logic signed [COORD_W-1:0] rsp_box_bottom
);

   // A stalled result transaction holds its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_inside_res) &&
      $stable(rsp_overflow) && $stable(rsp_vertex_count) && $stable(rsp_box_left) &&
      $stable(rsp_box_top) && $stable(rsp_box_right) && $stable(rsp_box_bottom))
      else $error("result changed while stalled");

   // The bounding box never turns inside out.
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_box_left <= rsp_box_right) && (rsp_box_top <= rsp_box_bottom))
      else $error("bounding box edges out of order");

   // An overflow comes only from an add, which never reports containment.
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflow && rsp_inside_res))
      else $error("overflow and inside reported together");

   // While a result transaction waits, no request transaction is taken.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while a result was waiting");

endmodule

bind polygon_point_containment_unit pcu_checker u_pcu_checker (.*);

`default_nettype wire

### bench/tb_polygon_point_containment_unit.sv
// Self-checking testbench for polygon_point_containment_unit: a directed table, then random
// polygons with queries; untyped items are checked against a crossing-number predictor with its own state.
// Depends on pcu_pkg and the polygon_point_containment_unit RTL.
`default_nettype none

module tb_polygon_point_containment_unit;
   import pcu_pkg::*;

   localparam int          MAX_VERTICES  = MAX_VERTICES_DEF;
   localparam int          HALF_BOX      = 24;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          IDLE_LIMIT    = 3000;
   localparam int          RANDOM_ITEMS  = 1200;
   localparam int          ROW_COUNT     = 25;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam coord_type   COORD_HI      = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type   COORD_LO      = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum int {CROSS_NONE, CROSS_LEFT, CROSS_RIGHT} crossing_type;

   typedef struct packed {
      logic                   in_poly;
      logic                   overflow;
      logic [COUNT_OUT_W-1:0] count;
      coord_type              left;
      coord_type              top;
      coord_type              right;
      coord_type              bottom;
   } containment_result_type;

   typedef struct packed {
      logic [1:0]             op;
      coord_type              x;
      coord_type              y;
      logic                   typed;
      containment_result_type want;
   } stimulus_row_type;

   localparam containment_result_type UNTYPED = '0;

   // Expected results are typed in only for reset, the extreme corners and a clear.
   localparam stimulus_row_type STIMULUS_ROWS [ROW_COUNT] = '{
      '{OP_QUERY, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 0}},
      '{OP_ADD, 524287, 524287, 1, '{0, 0, 1, 524263, 524263, 524287, 524287}},
      '{OP_QUERY, 524287, 524287, 1, '{0, 0, 1, 524263, 524263, 524287, 524287}},
      '{OP_CLEAR, 5, 5, 1, '{0, 0, 0, 524263, 524263, 524287, 524287}},
      '{OP_ADD, -524288, -524288, 1, '{0, 0, 1, -524288, -524288, -524264, -524264}},
      '{OP_ADD, -524288, 524287, 0, UNTYPED},
      '{OP_QUERY, -524288, 0, 0, UNTYPED},
      '{OP_ADD, 524287, -524288, 0, UNTYPED},
      '{OP_QUERY, 0, 0, 0, UNTYPED},
      '{OP_QUERY, -524288, -524288, 0, UNTYPED},
      '{OP_QUERY, 524287, 524287, 0, UNTYPED},
      '{OP_UNUSED, -1, -1, 0, UNTYPED},
      '{OP_CLEAR, 0, 0, 0, UNTYPED},
      '{OP_ADD, 0, 0, 0, UNTYPED},
      '{OP_ADD, 160, 0, 0, UNTYPED},
      '{OP_ADD, 160, 160, 0, UNTYPED},
      '{OP_ADD, 16, 16, 0, UNTYPED},
      '{OP_ADD, 0, 160, 0, UNTYPED},
      '{OP_ADD, 0, 160, 0, UNTYPED},
      '{OP_QUERY, 80, 80, 0, UNTYPED},
      '{OP_QUERY, 80, 0, 0, UNTYPED},
      '{OP_QUERY, 0, 80, 0, UNTYPED},
      '{OP_QUERY, 200, 80, 0, UNTYPED},
      '{OP_QUERY, 16, 16, 0, UNTYPED},
      '{OP_QUERY, -1, 160, 0, UNTYPED}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_opcode;
   coord_type              req_x_coord;
   coord_type              req_y_coord;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_inside_res;
   logic                   rsp_overflow;
   logic [COUNT_OUT_W-1:0] rsp_vertex_count;
   coord_type              rsp_box_left;
   coord_type              rsp_box_top;
   coord_type              rsp_box_right;
   coord_type              rsp_box_bottom;

   coord_type              vertex_x [MAX_VERTICES];
   coord_type              vertex_y [MAX_VERTICES];
   int                     held_vertices;
   coord_type              bbox_left, bbox_top, bbox_right, bbox_bottom;

   containment_result_type expected_results [$];
   int                     mismatch_count;
   int                     idle_cycles;
   int                     items_sent;
   bit                     sender_gaps_on;
   bit                     hold_results;

   polygon_point_containment_unit #(.MAX_VERTICES(MAX_VERTICES)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_overflow    (rsp_overflow),
      .rsp_vertex_count(rsp_vertex_count),
      .rsp_box_left    (rsp_box_left),
      .rsp_box_top     (rsp_box_top),
      .rsp_box_right   (rsp_box_right),
      .rsp_box_bottom  (rsp_box_bottom)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic coord_type clamp_coord(int v);
      if (v < int'(COORD_LO)) return COORD_LO;
      if (v > int'(COORD_HI)) return COORD_HI;
      return coord_type'(v);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   function automatic crossing_type edge_crossing(coord_type ax, coord_type ay, coord_type bx,
                                                  coord_type by, coord_type px, coord_type py);
      longint dy;
      longint num;
      dy = longint'(by) - longint'(ay);
      if (dy == 0) return CROSS_NONE;
      if (dy > 0 && (py < ay || py > by)) return CROSS_NONE;
      if (dy < 0 && (py > ay || py < by)) return CROSS_NONE;
      // The sign of num times dy tells on which side of the point the crossing lies.
      num = (longint'(ax) - longint'(px)) * dy + (longint'(py) - longint'(ay))
            * (longint'(bx) - longint'(ax));
      if ((dy > 0 && num > 0) || (dy < 0 && num < 0)) return CROSS_RIGHT;
      return CROSS_LEFT;
   endfunction

   function automatic containment_result_type predict_containment(logic [1:0] op,
                                                                  coord_type x, coord_type y);
      containment_result_type res;
      coord_type              l, t, r, b;
      int                     left_hits, right_hits, j;
      crossing_type           side;
      res = '0;
      left_hits = 0;
      right_hits = 0;
      if (op == OP_ADD) begin
         if (held_vertices >= MAX_VERTICES) begin
            res.overflow = 1'b1;
         end else begin
            l = clamp_coord(int'(x) - HALF_BOX);
            r = clamp_coord(int'(x) + HALF_BOX);
            t = clamp_coord(int'(y) - HALF_BOX);
            b = clamp_coord(int'(y) + HALF_BOX);
            if (held_vertices == 0) begin
               bbox_left = l;
               bbox_top = t;
               bbox_right = r;
               bbox_bottom = b;
            end else if (!(x >= bbox_left && x <= bbox_right &&
                           y >= bbox_top && y <= bbox_bottom)) begin
               if (l < bbox_left) bbox_left = l;
               if (t < bbox_top) bbox_top = t;
               if (r > bbox_right) bbox_right = r;
               if (b > bbox_bottom) bbox_bottom = b;
            end
            vertex_x[held_vertices] = x;
            vertex_y[held_vertices] = y;
            held_vertices++;
         end
      end else if (op == OP_CLEAR) begin
         held_vertices = 0;
      end else if (op == OP_QUERY && held_vertices >= 2) begin
         for (int i = 0; i < held_vertices; i++) begin
            j = (i + 1 < held_vertices) ? i + 1 : 0;
            side = edge_crossing(vertex_x[i], vertex_y[i], vertex_x[j], vertex_y[j], x, y);
            if (side == CROSS_RIGHT) right_hits++;
            else if (side == CROSS_LEFT) left_hits++;
         end
         res.in_poly = left_hits[0] | right_hits[0];
      end
      res.count = COUNT_OUT_W'(held_vertices);
      res.left = bbox_left;
      res.top = bbox_top;
      res.right = bbox_right;
      res.bottom = bbox_bottom;
      return res;
   endfunction

   // Called at a falling edge; returns at the falling edge where the next transaction may start.
   task automatic send_item(logic [1:0] op, coord_type x, coord_type y,
                            bit typed, containment_result_type want);
      containment_result_type res;
      int                     gap;
      req_opcode = op;
      req_x_coord = x;
      req_y_coord = y;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      res = predict_containment(op, x, y);
      expected_results.push_back(typed ? want : res);
      if (op != OP_UNUSED) items_sent++;
      @(negedge clock);
      gap = sender_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_results_drained();
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   function automatic coord_type random_coord(int base, int span);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return $urandom_range(0, 1) ? COORD_HI : COORD_LO;
      if (r == 1) return coord_type'($urandom());
      return clamp_coord(base + int'($urandom_range(0, span)));
   endfunction

   function automatic coord_type query_x(int base, int span, int pick);
      if (held_vertices > 0 && $urandom_range(0, 3) == 0) return vertex_x[pick];
      return random_coord(base, span);
   endfunction

   function automatic coord_type query_y(int base, int span, int pick);
      if (held_vertices > 0 && $urandom_range(0, 1) == 0) return vertex_y[pick];
      return random_coord(base, span);
   endfunction

   task automatic send_polygon(int vertex_total, int query_total, bit clear_first);
      int        span, base, pick;
      coord_type qx, qy;
      span = $urandom_range(0, 2) == 0 ? $urandom_range(16, 96) : $urandom_range(200, 20000);
      if ($urandom_range(0, 9) == 0) span = 1000000;
      base = int'(coord_type'($urandom())) - span / 2;
      if (clear_first) send_item(OP_CLEAR, coord_type'($urandom()), coord_type'($urandom()),
                                 0, UNTYPED);
      repeat (vertex_total)
         send_item(OP_ADD, random_coord(base, span), random_coord(base, span), 0, UNTYPED);
      repeat (query_total) begin
         pick = held_vertices > 0 ? $urandom_range(0, held_vertices - 1) : 0;
         qx = query_x(base, span, pick);
         qy = query_y(base, span, pick);
         send_item(OP_QUERY, qx, qy, 0, UNTYPED);
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 4))
         send_item(2'($urandom_range(0, 3)), coord_type'($urandom()), coord_type'($urandom()),
                   0, UNTYPED);
   endtask

   initial begin
      bit hold_done;
      int vertex_total;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_ADD;
      req_x_coord = '0;
      req_y_coord = '0;
      held_vertices = 0;
      bbox_left = '0;
      bbox_top = '0;
      bbox_right = '0;
      bbox_bottom = '0;
      sender_gaps_on = 1'b1;
      hold_results = 1'b0;
      hold_done = 1'b0;
      items_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (STIMULUS_ROWS[k])
         send_item(STIMULUS_ROWS[k].op, STIMULUS_ROWS[k].x, STIMULUS_ROWS[k].y,
                   STIMULUS_ROWS[k].typed, STIMULUS_ROWS[k].want);
      wait_results_drained();

      while (items_sent < RANDOM_ITEMS) begin
         sender_gaps_on = $urandom_range(0, 3) != 0;
         if (!hold_done && items_sent > 400) begin
            // The receiver holds off while a burst of adds fills the block.
            wait_results_drained();
            hold_done = 1'b1;
            hold_results = 1'b1;
            sender_gaps_on = 1'b0;
            send_polygon(MAX_VERTICES + 4, 2, 1);
         end else if ($urandom_range(0, 19) == 0) begin
            send_noise();
         end else begin
            vertex_total = $urandom_range(0, 14) == 0 ? $urandom_range(MAX_VERTICES - 4,
                                                                       MAX_VERTICES + 6)
                                                      : $urandom_range(0, 12);
            send_polygon(vertex_total, $urandom_range(1, 6), $urandom_range(0, 4) != 0);
         end
      end

      wait_results_drained();
      repeat (MAX_VERTICES + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("polygon_point_containment_unit test passed");
      end else begin
         $display("polygon_point_containment_unit test failed");
      end
      $finish;
   end

   initial begin
      int run_left;
      rsp_stall = 1'b0;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_results = 1'b0;
            rsp_stall = 1'b0;
         end else if (run_left == 0) begin
            rsp_stall = $urandom_range(0, 2) == 0;
            run_left = pick_gap();
         end else begin
            run_left--;
         end
      end
   end

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      end
   endfunction

   initial mismatch_count = 0;

   always @(posedge clock) begin
      containment_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            $error("result transaction arrived with no transaction outstanding");
         end else begin
            want = expected_results.pop_front();
            check_field("inside_res", want.in_poly, rsp_inside_res);
            check_field("overflow", want.overflow, rsp_overflow);
            check_field("vertex_count", want.count, rsp_vertex_count);
            check_field("box_left", want.left, rsp_box_left);
            check_field("box_top", want.top, rsp_box_top);
            check_field("box_right", want.right, rsp_box_right);
            check_field("box_bottom", want.bottom, rsp_box_bottom);
         end
      end
   end

   initial idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("polygon_point_containment_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire
